// File: rtl/core/evg_pkg.sv
`default_nettype none
package evg_pkg;

  localparam int ANGLE_STEPS   = 128;
  localparam int COORD_BITS    = 32;
  localparam int QUARTER_STEPS = ANGLE_STEPS / 4;
  localparam int TAB_N         = QUARTER_STEPS / 2 + 1;
  localparam int TAB_AW        = $clog2(TAB_N);
  localparam int K_W           = $clog2(ANGLE_STEPS);
  localparam int J_W           = $clog2(QUARTER_STEPS);
  localparam int IDX_W         = 8;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int EXT_W  = 31;

  localparam logic [CFG_AW-1:0] REG_CENTER_X     = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] REG_CENTER_Y     = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] REG_FULL_WIDTH   = CFG_AW'(2);
  localparam logic [CFG_AW-1:0] REG_FULL_HEIGHT  = CFG_AW'(3);
  localparam logic [CFG_AW-1:0] REG_HIGH_QUALITY = CFG_AW'(4);

  // q1.30 trig values and normalized magnitudes
  localparam int TRIG_W  = 31;
  localparam int PROD_W  = 2 * TRIG_W;
  localparam int RAD_W   = 64;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int Q_W     = 31;
  localparam int SQRT_CELLS = ROOT_W;
  localparam int DIV_CELLS  = Q_W;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef logic [TRIG_W-1:0] trig_tab_t [TAB_N];

  // taylor series sin or cos of step j, evaluated at elaboration
  function automatic trig_tab_t make_trig_tab(input bit want_cos);
    trig_tab_t tab;
    longint unsigned x, x2, st, ct;
    longint ssum, csum;
    for (int j = 0; j < TAB_N; j++) begin
      x  = (64'(2 * j) * PI_Q30 + 64'(ANGLE_STEPS / 2)) / 64'(ANGLE_STEPS);
      x2 = (x * x + (64'd1 << 29)) >> 30;
      ssum = longint'(x);
      csum = longint'(ONE_Q30);
      st = x;
      ct = ONE_Q30;
      for (int n = 1; n <= 7; n++) begin
        st = ((st * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        ct = ((ct * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
        if ((n % 2) == 1) begin
          ssum = ssum - longint'(st);
          csum = csum - longint'(ct);
        end else begin
          ssum = ssum + longint'(st);
          csum = csum + longint'(ct);
        end
      end
      if (ssum < 0) ssum = 0;
      if (ssum > longint'(ONE_Q30)) ssum = longint'(ONE_Q30);
      if (csum < 0) csum = 0;
      if (csum > longint'(ONE_Q30)) csum = longint'(ONE_Q30);
      tab[j] = want_cos ? csum[TRIG_W-1:0] : ssum[TRIG_W-1:0];
    end
    return tab;
  endfunction

  localparam trig_tab_t SIN_TAB = make_trig_tab(1'b0);
  localparam trig_tab_t COS_TAB = make_trig_tab(1'b1);

  typedef struct packed {
    logic valid;
    logic closing;
    logic degen;
    logic c_neg;
    logic s_neg;
    logic c_nz;
    logic s_nz;
  } evg_tag_t;

  typedef struct packed {
    evg_tag_t            tag;
    logic [RAD_W-1:0]    rad;
    logic [REM_W-1:0]    rem;
    logic [ROOT_W-1:0]   root;
    logic [TRIG_W-1:0]   u;
    logic [TRIG_W-1:0]   v;
  } evg_sq_t;

  typedef struct packed {
    evg_tag_t            tag;
    logic [ROOT_W-1:0]   d;
    logic [ROOT_W-1:0]   ru;
    logic [ROOT_W-1:0]   rv;
    logic [Q_W-1:0]      lu;
    logic [Q_W-1:0]      lv;
    logic [Q_W-1:0]      qu;
    logic [Q_W-1:0]      qv;
  } evg_dv_t;

endpackage
`default_nettype wire

// File: rtl/core/evg_front.sv
`default_nettype none
module evg_front import evg_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             in_valid,
  input  wire logic [IDX_W-1:0] in_index,
  input  wire logic [EXT_W-1:0] full_width,
  input  wire logic [EXT_W-1:0] full_height,
  input  wire logic             high_quality,
  output evg_sq_t               sq_o
);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;
  localparam int GROUPS   = RAD_W / 8;
  localparam int MSB_W    = $clog2(RAD_W);
  localparam int NORM_MSB = TRIG_W - 1;

  evg_tag_t t1_nxt, t1_r, t2_r, t3_r, t4_r, t5_r, t6_r, t7_r, t8_r;

  // stage 1: index to angle, table lookup
  logic [IDX_W-1:0]  n_cnt, idx_c, m_idx;
  logic [K_W-1:0]    k;
  logic [1:0]        quad;
  logic [J_W-1:0]    j, jj;
  logic              fold;
  logic [TRIG_W-1:0] bs, bc, cm1_nxt, sm1_nxt, cm1_r, sm1_r;

  always_comb begin
    n_cnt = high_quality ? IDX_W'(ANGLE_STEPS) : IDX_W'(ANGLE_STEPS / 2);
    t1_nxt = '0;
    t1_nxt.valid   = in_valid;
    t1_nxt.closing = in_index >= n_cnt;
    t1_nxt.degen   = (full_width == '0) && (full_height == '0);
    idx_c = t1_nxt.closing ? n_cnt : in_index;
    m_idx = high_quality ? idx_c : {idx_c[IDX_W-2:0], 1'b0};
    k     = K_W'(0) - m_idx[K_W-1:0];
    quad  = k[K_W-1 -: 2];
    j     = k[J_W-1:0];
    fold  = {1'b0, j} > (J_W+1)'(QUARTER_STEPS / 2);
    jj    = fold ? J_W'(QUARTER_STEPS) - j : j;
    bs    = fold ? COS_TAB[TAB_AW'(jj)] : SIN_TAB[TAB_AW'(jj)];
    bc    = fold ? SIN_TAB[TAB_AW'(jj)] : COS_TAB[TAB_AW'(jj)];
    cm1_nxt = bc;
    sm1_nxt = bs;
    case (quad)
      QUAD_0: begin
        cm1_nxt = bc;
        sm1_nxt = bs;
      end
      QUAD_1: begin
        cm1_nxt = bs;
        sm1_nxt = bc;
        t1_nxt.c_neg = bs != '0;
      end
      QUAD_2: begin
        cm1_nxt = bc;
        sm1_nxt = bs;
        t1_nxt.c_neg = bc != '0;
        t1_nxt.s_neg = bs != '0;
      end
      QUAD_3: begin
        cm1_nxt = bs;
        sm1_nxt = bc;
        t1_nxt.s_neg = bc != '0;
      end
      default: begin
        cm1_nxt = bc;
        sm1_nxt = bs;
      end
    endcase
    t1_nxt.c_nz = cm1_nxt != '0;
    t1_nxt.s_nz = sm1_nxt != '0;
  end

  // stage 2..8 payload
  logic [PROD_W-1:0]        u2_r, v2_r, u3_r, v3_r, mx3_r, u4_r, v4_r, u5_r, v5_r;
  logic [GROUPS-1:0]        any4_nxt, any4_r;
  logic [GROUPS-1:0][2:0]   pos4_nxt, pos4_r;
  logic [RAD_W-1:0]         mx_pad;
  logic [MSB_W-1:0]         msb5;
  logic [MSB_W-1:0]         amt5_nxt, amt5_r;
  logic                     right5_nxt, right5_r, zero5_nxt, zero5_r;
  logic [PROD_W-1:0]        ush, vsh;
  logic [TRIG_W-1:0]        un6_nxt, vn6_nxt, un6_r, vn6_r, un7_r, vn7_r, un8_r, vn8_r;
  logic [PROD_W-1:0]        uu7_r, vv7_r;
  logic [RAD_W-1:0]         rad8_r;

  // leading one per byte group
  always_comb begin
    mx_pad = RAD_W'(mx3_r);
    for (int g = 0; g < GROUPS; g++) begin
      any4_nxt[g] = |mx_pad[g*8 +: 8];
      pos4_nxt[g] = 3'd0;
      for (int i = 0; i < 8; i++) begin
        if (mx_pad[g*8 + i]) pos4_nxt[g] = 3'(i);
      end
    end
  end

  always_comb begin
    msb5 = '0;
    for (int g = 0; g < GROUPS; g++) begin
      if (any4_r[g]) msb5 = {3'(g), pos4_r[g]};
    end
    zero5_nxt  = any4_r == '0;
    right5_nxt = msb5 > MSB_W'(NORM_MSB);
    amt5_nxt   = right5_nxt ? msb5 - MSB_W'(NORM_MSB) : MSB_W'(NORM_MSB) - msb5;
  end

  // bring the larger of u, v to bit NORM_MSB
  always_comb begin
    if (right5_r) begin
      ush = u5_r >> amt5_r;
      vsh = v5_r >> amt5_r;
    end else begin
      ush = u5_r << amt5_r;
      vsh = v5_r << amt5_r;
    end
    un6_nxt = zero5_r ? '0 : ush[TRIG_W-1:0];
    vn6_nxt = zero5_r ? '0 : vsh[TRIG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r.valid <= 1'b0;
      t2_r.valid <= 1'b0;
      t3_r.valid <= 1'b0;
      t4_r.valid <= 1'b0;
      t5_r.valid <= 1'b0;
      t6_r.valid <= 1'b0;
      t7_r.valid <= 1'b0;
      t8_r.valid <= 1'b0;
    end else if (adv) begin
      t1_r <= t1_nxt;
      t2_r <= t1_r;
      t3_r <= t2_r;
      t4_r <= t3_r;
      t5_r <= t4_r;
      t6_r <= t5_r;
      t7_r <= t6_r;
      t8_r <= t7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cm1_r    <= cm1_nxt;
      sm1_r    <= sm1_nxt;
      u2_r     <= PROD_W'(full_height) * PROD_W'(cm1_r);
      v2_r     <= PROD_W'(full_width) * PROD_W'(sm1_r);
      u3_r     <= u2_r;
      v3_r     <= v2_r;
      mx3_r    <= (u2_r > v2_r) ? u2_r : v2_r;
      u4_r     <= u3_r;
      v4_r     <= v3_r;
      any4_r   <= any4_nxt;
      pos4_r   <= pos4_nxt;
      u5_r     <= u4_r;
      v5_r     <= v4_r;
      amt5_r   <= amt5_nxt;
      right5_r <= right5_nxt;
      zero5_r  <= zero5_nxt;
      un6_r    <= un6_nxt;
      vn6_r    <= vn6_nxt;
      uu7_r    <= PROD_W'(un6_r) * PROD_W'(un6_r);
      vv7_r    <= PROD_W'(vn6_r) * PROD_W'(vn6_r);
      un7_r    <= un6_r;
      vn7_r    <= vn6_r;
      rad8_r   <= RAD_W'(uu7_r) + RAD_W'(vv7_r);
      un8_r    <= un7_r;
      vn8_r    <= vn7_r;
    end
  end

  always_comb begin
    sq_o.tag  = t8_r;
    sq_o.rad  = rad8_r;
    sq_o.rem  = '0;
    sq_o.root = '0;
    sq_o.u    = un8_r;
    sq_o.v    = vn8_r;
  end

endmodule
`default_nettype wire

// File: rtl/core/evg_sqrt_cell.sv
`default_nettype none
module evg_sqrt_cell import evg_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    adv,
  input  wire evg_sq_t sq_i,
  output evg_sq_t      sq_o
);

  evg_sq_t sq_nxt, sq_r;
  logic [REM_W+1:0] acc, trial, diff;

  // one root bit: bring down two radicand bits, try root*4+1
  always_comb begin
    sq_nxt = sq_i;
    acc    = {sq_i.rem, sq_i.rad[RAD_W-1 -: 2]};
    trial  = {2'b00, sq_i.root, 2'b01};
    diff   = acc - trial;
    if (acc >= trial) begin
      sq_nxt.rem  = diff[REM_W-1:0];
      sq_nxt.root = {sq_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      sq_nxt.rem  = acc[REM_W-1:0];
      sq_nxt.root = {sq_i.root[ROOT_W-2:0], 1'b0};
    end
    sq_nxt.rad = {sq_i.rad[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r.tag.valid <= 1'b0;
    end else if (adv) begin
      sq_r <= sq_nxt;
    end
  end

  assign sq_o = sq_r;

endmodule
`default_nettype wire

// File: rtl/core/evg_div_cell.sv
`default_nettype none
module evg_div_cell import evg_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    adv,
  input  wire evg_dv_t dv_i,
  output evg_dv_t      dv_o
);

  evg_dv_t dv_nxt, dv_r;
  logic [ROOT_W:0] shu, shv, difu, difv, dext;

  // one quotient bit for both u/d and v/d
  always_comb begin
    dv_nxt = dv_i;
    dext   = {1'b0, dv_i.d};
    shu    = {dv_i.ru, dv_i.lu[Q_W-1]};
    shv    = {dv_i.rv, dv_i.lv[Q_W-1]};
    difu   = shu - dext;
    difv   = shv - dext;
    if (shu >= dext) begin
      dv_nxt.ru = difu[ROOT_W-1:0];
      dv_nxt.qu = {dv_i.qu[Q_W-2:0], 1'b1};
    end else begin
      dv_nxt.ru = shu[ROOT_W-1:0];
      dv_nxt.qu = {dv_i.qu[Q_W-2:0], 1'b0};
    end
    if (shv >= dext) begin
      dv_nxt.rv = difv[ROOT_W-1:0];
      dv_nxt.qv = {dv_i.qv[Q_W-2:0], 1'b1};
    end else begin
      dv_nxt.rv = shv[ROOT_W-1:0];
      dv_nxt.qv = {dv_i.qv[Q_W-2:0], 1'b0};
    end
    dv_nxt.lu = {dv_i.lu[Q_W-2:0], 1'b0};
    dv_nxt.lv = {dv_i.lv[Q_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r.tag.valid <= 1'b0;
    end else if (adv) begin
      dv_r <= dv_nxt;
    end
  end

  assign dv_o = dv_r;

endmodule
`default_nettype wire

// File: rtl/core/evg_back.sv
`default_nettype none
module evg_back import evg_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire evg_dv_t               dv_i,
  input  wire logic [COORD_BITS-1:0] center_x,
  input  wire logic [COORD_BITS-1:0] center_y,
  input  wire logic [EXT_W-1:0]      full_width,
  input  wire logic [EXT_W-1:0]      full_height,
  output logic                       out_valid,
  output logic [COORD_BITS-1:0]      out_x,
  output logic [COORD_BITS-1:0]      out_y,
  output logic                       out_closing,
  output logic                       out_degen
);

  localparam int SUM_W = COORD_BITS + 2;

  evg_tag_t          t1_r;
  logic              dzero;
  logic [Q_W-1:0]    ux, uy;
  logic [PROD_W-1:0] px_r, py_r, prx, pry;
  logic [EXT_W-1:0]  ox, oy;
  logic [COORD_BITS-1:0] x_nxt, y_nxt;

  // zero root: unit direction falls back to the remaining axis
  always_comb begin
    dzero = dv_i.d == '0;
    ux = dzero ? (dv_i.tag.c_nz ? Q_W'(ONE_Q30) : '0) : dv_i.qu;
    uy = dzero ? (dv_i.tag.s_nz ? Q_W'(ONE_Q30) : '0) : dv_i.qv;
  end

  function automatic logic [COORD_BITS-1:0] sat_add(input logic [COORD_BITS-1:0] c,
                                                    input logic [EXT_W-1:0] mag,
                                                    input logic neg);
    logic signed [SUM_W-1:0] s;
    s = neg ? SUM_W'(signed'(c)) - SUM_W'(mag) : SUM_W'(signed'(c)) + SUM_W'(mag);
    if (s[SUM_W-1:COORD_BITS-1] == '0 || s[SUM_W-1:COORD_BITS-1] == '1) begin
      return s[COORD_BITS-1:0];
    end else if (s[SUM_W-1]) begin
      return {1'b1, (COORD_BITS-1)'(0)};
    end else begin
      return {1'b0, {(COORD_BITS-1){1'b1}}};
    end
  endfunction

  always_comb begin
    prx = px_r + PROD_W'(ONE_Q30);
    pry = py_r + PROD_W'(ONE_Q30);
    ox  = t1_r.degen ? '0 : prx[PROD_W-1 -: EXT_W];
    oy  = t1_r.degen ? '0 : pry[PROD_W-1 -: EXT_W];
    x_nxt = sat_add(center_x, ox, t1_r.c_neg);
    y_nxt = sat_add(center_y, oy, t1_r.s_neg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r.valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (adv) begin
      t1_r      <= dv_i.tag;
      out_valid <= t1_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r        <= PROD_W'(full_width) * PROD_W'(ux);
      py_r        <= PROD_W'(full_height) * PROD_W'(uy);
      out_x       <= x_nxt;
      out_y       <= y_nxt;
      out_closing <= t1_r.closing;
      out_degen   <= t1_r.degen;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/ellipse_vertex_generator.sv
// ellipse vertex generator
// program center_x, center_y, full_width, full_height and high_quality through
// the cfg port while no request is in flight; each write lands on the edge where
// cfg_wr_en is high
// every request on the in_ channel carries a vertex index and gives exactly one
// result on the out_ channel: x and y in q16.16 in out_tdata, tlast marks the
// ring-closing vertex (index at or above the vertex count), tuser flags a
// zero-size ellipse, in which case the center is returned
// throughput is one vertex per cycle unless the chain holds; a request reaches
// out_tvalid through 8 front stages (angle lookup, multiply, normalize, square),
// 32 square-root cells, 31 divider cells and 2 output stages
// when out_tready is low with a result waiting, the whole chain holds and
// in_tready drops in the same cycle; nothing is lost or repeated
// reset clears the configuration registers to zero and empties the chain
`default_nettype none
module ellipse_vertex_generator import evg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_wdata,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IDX_W-1:0]  in_tdata,   // [7:0] vertex_index
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [2*COORD_BITS-1:0] out_tdata, // [31:0] vertex_x, [63:32] vertex_y
  output logic                   out_tlast,  // closing_vertex
  output logic                   out_tuser   // [0] degenerate_point
);

  logic [COORD_BITS-1:0] center_x_r, center_y_r;
  logic [EXT_W-1:0]      full_width_r, full_height_r;
  logic                  high_quality_r;
  logic                  adv;
  logic [COORD_BITS-1:0] vx, vy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r     <= '0;
      center_y_r     <= '0;
      full_width_r   <= '0;
      full_height_r  <= '0;
      high_quality_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_CENTER_X:     center_x_r     <= cfg_wdata[COORD_BITS-1:0];
        REG_CENTER_Y:     center_y_r     <= cfg_wdata[COORD_BITS-1:0];
        REG_FULL_WIDTH:   full_width_r   <= cfg_wdata[EXT_W-1:0];
        REG_FULL_HEIGHT:  full_height_r  <= cfg_wdata[EXT_W-1:0];
        REG_HIGH_QUALITY: high_quality_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  evg_sq_t sq_chain [SQRT_CELLS+1];
  evg_dv_t dv_chain [DIV_CELLS+1];

  evg_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .in_valid     (in_tvalid),
    .in_index     (in_tdata),
    .full_width   (full_width_r),
    .full_height  (full_height_r),
    .high_quality (high_quality_r),
    .sq_o         (sq_chain[0])
  );

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    evg_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .sq_i  (sq_chain[i]),
      .sq_o  (sq_chain[i+1])
    );
  end

  // divider start: first partial remainder is u/2, u's low bit leads the shifted-in bits
  always_comb begin
    dv_chain[0].tag = sq_chain[SQRT_CELLS].tag;
    dv_chain[0].d   = sq_chain[SQRT_CELLS].root;
    dv_chain[0].ru  = ROOT_W'(sq_chain[SQRT_CELLS].u[TRIG_W-1:1]);
    dv_chain[0].rv  = ROOT_W'(sq_chain[SQRT_CELLS].v[TRIG_W-1:1]);
    dv_chain[0].lu  = {sq_chain[SQRT_CELLS].u[0], (Q_W-1)'(0)};
    dv_chain[0].lv  = {sq_chain[SQRT_CELLS].v[0], (Q_W-1)'(0)};
    dv_chain[0].qu  = '0;
    dv_chain[0].qv  = '0;
  end

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    evg_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .dv_i  (dv_chain[i]),
      .dv_o  (dv_chain[i+1])
    );
  end

  evg_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .dv_i        (dv_chain[DIV_CELLS]),
    .center_x    (center_x_r),
    .center_y    (center_y_r),
    .full_width  (full_width_r),
    .full_height (full_height_r),
    .out_valid   (out_tvalid),
    .out_x       (vx),
    .out_y       (vy),
    .out_closing (out_tlast),
    .out_degen   (out_tuser)
  );

  assign out_tdata = {vy, vx};

endmodule
`default_nettype wire

// File: sim/testbench.sv
`default_nettype none
module testbench import evg_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 73;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic [31:0] vx;
    logic [31:0] vy;
    logic        closing;
    logic        degen;
  } vertex_t;

  typedef struct {
    bit          is_cfg;
    bit          drain;
    logic [2:0]  addr;
    logic [31:0] data;
    logic [7:0]  index;
  } request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IDX_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [2*COORD_BITS-1:0] out_tdata;
  logic out_tlast;
  logic out_tuser;

  ellipse_vertex_generator DUT (.*);

  always #1 clk = ~clk;

  // predictor copy of the registers
  longint      pcx = 0, pcy = 0;
  longint unsigned pw = 0, ph = 0;
  bit          phq = 0;

  request_t pending[$];
  vertex_t  expected_vertices[$];
  int  errors = 0;
  int  vertices_seen = 0;
  int  closing_seen = 0;
  int  degen_seen = 0;
  longint cycles = 0;
  bit  stimulus_done = 0;
  bit  in_acc = 0;          // request taken at the last rising edge
  bit  long_stall_done = 0;
  int  hold_off = 0;        // receiver long stall request
  int  send_gap = 0;
  int  recv_gap = 0;

  function automatic void quarter_trig(input longint unsigned j,
                                       output longint unsigned s,
                                       output longint unsigned c);
    longint unsigned x, x2, st, ct;
    longint ssum, csum;
    x = (2 * j * PI_Q30 + ANGLE_STEPS / 2) / ANGLE_STEPS;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    ssum = longint'(x);
    csum = longint'(ONE_Q30);
    st = x;
    ct = ONE_Q30;
    for (int n = 1; n <= 7; n++) begin
      st = ((st * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      ct = ((ct * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        ssum -= longint'(st);
        csum -= longint'(ct);
      end else begin
        ssum += longint'(st);
        csum += longint'(ct);
      end
    end
    if (ssum < 0) ssum = 0;
    if (ssum > longint'(ONE_Q30)) ssum = longint'(ONE_Q30);
    if (csum < 0) csum = 0;
    if (csum > longint'(ONE_Q30)) csum = longint'(ONE_Q30);
    s = longint'(ssum);
    c = longint'(csum);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned val);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > val) b >>= 2;
    while (b != 0) begin
      if (val >= r + b) begin
        val -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] saturate_coord(input longint ctr,
                                                 input longint unsigned mag,
                                                 input bit neg);
    longint sum;
    sum = neg ? ctr - longint'(mag) : ctr + longint'(mag);
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[31:0];
  endfunction

  function automatic vertex_t vertex_of(input logic [7:0] index);
    vertex_t r;
    longint unsigned idx, n, m, k, q, j, bs, bc, u, v, mx, d, ux, uy, ox, oy;
    longint s, c;
    idx = index;
    n = phq ? ANGLE_STEPS : ANGLE_STEPS / 2;
    r.closing = idx >= n;
    if (r.closing) idx = n;
    if (pw == 0 && ph == 0) begin
      r.vx = saturate_coord(pcx, 0, 0);
      r.vy = saturate_coord(pcy, 0, 0);
      r.degen = 1'b1;
      return r;
    end
    r.degen = 1'b0;
    m = phq ? idx : 2 * idx;
    k = (ANGLE_STEPS - m) % ANGLE_STEPS;
    q = (k / QUARTER_STEPS) & 3;
    j = k % QUARTER_STEPS;
    if (2 * j > QUARTER_STEPS) quarter_trig(QUARTER_STEPS - j, bc, bs);
    else quarter_trig(j, bs, bc);
    case (q)
      0: begin c = bc;  s = bs;  end
      1: begin c = -longint'(bs); s = bc; end
      2: begin c = -longint'(bc); s = -longint'(bs); end
      default: begin c = bs; s = -longint'(bc); end
    endcase
    u = ph * longint'(c < 0 ? -c : c);
    v = pw * longint'(s < 0 ? -s : s);
    mx = u > v ? u : v;
    while (mx >= (64'd1 << 31)) begin u >>= 1; v >>= 1; mx >>= 1; end
    while (mx != 0 && mx < ONE_Q30) begin u <<= 1; v <<= 1; mx <<= 1; end
    d = int_sqrt(u * u + v * v);
    if (d == 0) begin
      ux = (c != 0) ? ONE_Q30 : 0;
      uy = (s != 0) ? ONE_Q30 : 0;
    end else begin
      ux = (u << 30) / d;
      uy = (v << 30) / d;
    end
    ox = (pw * ux + ONE_Q30) >> 31;
    oy = (ph * uy + ONE_Q30) >> 31;
    r.vx = saturate_coord(pcx, ox, c < 0);
    r.vy = saturate_coord(pcy, oy, s < 0);
    return r;
  endfunction

  function automatic void store_register(input logic [2:0] addr, input logic [31:0] data);
    case (addr)
      REG_CENTER_X:     pcx = longint'(signed'(data));
      REG_CENTER_Y:     pcy = longint'(signed'(data));
      REG_FULL_WIDTH:   pw = data[30:0];
      REG_FULL_HEIGHT:  ph = data[30:0];
      REG_HIGH_QUALITY: phq = data[0];
      default: ;
    endcase
  endfunction

  task automatic push_cfg(input logic [2:0] addr, input logic [31:0] data);
    request_t r;
    r = '{1, 0, addr, data, 8'd0};
    pending.push_back(r);
  endtask

  task automatic push_vertex(input logic [7:0] index);
    request_t r;
    r = '{0, 0, 3'd0, 32'd0, index};
    pending.push_back(r);
  endtask

  task automatic push_drain();
    request_t r;
    r = '{0, 1, 3'd0, 32'd0, 8'd0};
    pending.push_back(r);
  endtask

  task automatic push_shape(input logic [31:0] cx, input logic [31:0] cy,
                            input logic [31:0] w, input logic [31:0] h, input bit hq);
    push_drain();
    push_cfg(REG_CENTER_X, cx);
    push_cfg(REG_CENTER_Y, cy);
    push_cfg(REG_FULL_WIDTH, w);
    push_cfg(REG_FULL_HEIGHT, h);
    push_cfg(REG_HIGH_QUALITY, {31'd0, hq});
  endtask

  function automatic logic [31:0] random_extent();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'h7fffffff;
      2: return $urandom_range(1, 255);
      3: return $urandom & 32'h7fffffff;
      default: return $urandom_range(1, 32'h00ffffff);
    endcase
  endfunction

  function automatic logic [31:0] random_center();
    case ($urandom_range(0, 4))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    // directed: reset state gives a degenerate point
    push_vertex(8'd0);
    push_vertex(8'd64);
    push_vertex(8'd255);
    push_shape(32'h00010000, 32'hffff0000, 32'h00080000, 32'h00040000, 1'b1);
    for (int i = 0; i <= 128; i += 16) push_vertex(i[7:0]);
    push_vertex(8'd129);
    push_vertex(8'd200);
    push_shape(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b0);
    push_vertex(8'd0); push_vertex(8'd16); push_vertex(8'd32); push_vertex(8'd48);
    push_vertex(8'd64); push_vertex(8'd65);
    // one extent zero: segment along x
    push_shape(32'd0, 32'd0, 32'h00100000, 32'd0, 1'b0);
    push_vertex(8'd0); push_vertex(8'd16); push_vertex(8'd8);
    push_shape(32'h12345678, 32'h87654321, 32'd0, 32'd0, 1'b1);
    push_vertex(8'd5); push_vertex(8'd128);
    for (int p = 0; p < 20; p++) begin
      push_shape(random_center(), random_center(), random_extent(), random_extent(),
                 $urandom_range(0, 1));
      // mostly full rings in order, else scattered indices
      if ($urandom_range(0, 2) != 0) begin
        for (int i = 0; i <= 128; i++) push_vertex(i[7:0]);
      end else begin
        for (int i = 0; i < 40; i++)
          push_vertex($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 128));
      end
    end
    push_drain();
  end

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_acc) begin
        // hold the current request
        cfg_wr_en <= 1'b0;
      end else if (send_gap > 0) begin
        cfg_wr_en <= 1'b0;
        in_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending.size() == 0) begin
        cfg_wr_en <= 1'b0;
        in_tvalid <= 1'b0;
        stimulus_done <= 1'b1;
      end else if (pending[0].drain) begin
        cfg_wr_en <= 1'b0;
        in_tvalid <= 1'b0;
        if (expected_vertices.size() == 0) begin
          void'(pending.pop_front());
          send_gap <= LATENCY + 5;
        end
      end else if (pending[0].is_cfg) begin
        in_tvalid <= 1'b0;
        cfg_wr_en <= 1'b1;
        cfg_addr <= pending[0].addr;
        cfg_wdata <= pending[0].data;
        store_register(pending[0].addr, pending[0].data);
        void'(pending.pop_front());
      end else begin
        cfg_wr_en <= 1'b0;
        in_tvalid <= 1'b1;
        in_tdata <= pending[0].index;
        void'(pending.pop_front());
        send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
      end
    end
  end

  always @(posedge clk) begin
    in_acc <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready)
      expected_vertices.push_back(vertex_of(in_tdata));
  end

  // receiver stalls, with one long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_off > 0) begin
        out_tready <= 1'b0;
        hold_off <= hold_off - 1;
      end else if (vertices_seen >= 200 && !long_stall_done) begin
        hold_off <= 400;
        long_stall_done <= 1'b1;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        out_tready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else begin
        out_tready <= 1'b1;
        if (out_tready && out_tvalid && $urandom_range(0, 3) == 0)
          recv_gap <= $urandom_range(0, 10);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    vertex_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_vertices.size() == 0) begin
        $display("%0t: unexpected vertex x=%h y=%h", $realtime, out_tdata[31:0],
                 out_tdata[63:32]);
        errors++;
      end else begin
        e = expected_vertices.pop_front();
        if (out_tdata[31:0] !== e.vx) begin
          $display("%0t: vertex_x expected %h actual %h", $realtime, e.vx, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[63:32] !== e.vy) begin
          $display("%0t: vertex_y expected %h actual %h", $realtime, e.vy, out_tdata[63:32]);
          errors++;
        end
        if (out_tlast !== e.closing) begin
          $display("%0t: closing_vertex expected %b actual %b", $realtime, e.closing,
                   out_tlast);
          errors++;
        end
        if (out_tuser !== e.degen) begin
          $display("%0t: degenerate_point expected %b actual %b", $realtime, e.degen,
                   out_tuser);
          errors++;
        end
      end
      vertices_seen++;
      closing_seen += out_tlast;
      degen_seen += out_tuser;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait (stimulus_done && expected_vertices.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("checked %0d vertices, %0d ring-closing and %0d degenerate,", vertices_seen,
             closing_seen, degen_seen);
    $display("over many ellipse shapes in both quality modes with random stalls");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end
endmodule
`default_nettype wire
